### rtl/gcht_pkg.sv
package gcht_pkg;

   localparam int TABLE_SLOTS = 8192;
   localparam int COUNT_BITS  = 8;
   localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
   localparam int REQ_BITS    = 9;
   localparam int LOAD_BITS   = 28;
   localparam int HASH_BITS   = 32;

   localparam logic [HASH_BITS-1:0]  HASH_MUL_X  = 32'h0005_0F1A;
   localparam logic [HASH_BITS-1:0]  HASH_MUL_Y  = 32'h0000_7651;
   localparam logic [REQ_BITS-1:0]   REQUEST_MAX = 9'd500;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
   localparam logic [SLOT_BITS-1:0]  LAST_SLOT   = SLOT_BITS'(TABLE_SLOTS - 1);

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_BUMP  = 2'd1,
      OP_FRAME = 2'd2,
      OP_LOAD  = 2'd3
   } op_type;

   typedef struct packed {
      logic                  active;
      logic                  valid;
      logic                  force_mark;
      logic [REQ_BITS-1:0]   req;
      logic [COUNT_BITS-1:0] obj;
   } slot_status_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic hash_mul;
      logic hash_sum;
      logic mod_step;
      logic probe_read;
      logic probe_check;
      logic bump_read;
      logic bump_write;
      logic bump_skip;
      logic sweep_step;
      logic sweep_end;
   } cmd_type;

   typedef struct packed {
      logic cnt_last;
      logic mod_done;
      logic probe_done;
      logic bump_ok;
   } stat_type;

endpackage

### rtl/gcht_ctrl.sv
module gcht_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_op,
   input  gcht_pkg::stat_type stat,
   output gcht_pkg::cmd_type  cmd,
   output logic               busy
);

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b000_0000_0001,
      S_IDLE   = 11'b000_0000_0010,
      S_HMUL   = 11'b000_0000_0100,
      S_HSUM   = 11'b000_0000_1000,
      S_MOD    = 11'b000_0001_0000,
      S_PRD    = 11'b000_0010_0000,
      S_PCHK   = 11'b000_0100_0000,
      S_BRD    = 11'b000_1000_0000,
      S_BCHK   = 11'b001_0000_0000,
      S_SWEEP  = 11'b010_0000_0000,
      S_SDRAIN = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.cnt_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (gcht_pkg::op_type'(req_op))
                  gcht_pkg::OP_ADD:  state_in = S_HMUL;
                  gcht_pkg::OP_BUMP: state_in = S_BRD;
                  default:           state_in = S_SWEEP;
               endcase
            end
         end
         S_HMUL: begin
            cmd.hash_mul = 1'b1;
            state_in = S_HSUM;
         end
         S_HSUM: begin
            cmd.hash_sum = 1'b1;
            state_in = S_MOD;
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_done) state_in = S_PRD;
         end
         S_PRD: begin
            cmd.probe_read = 1'b1;
            state_in = S_PCHK;
         end
         S_PCHK: begin
            cmd.probe_check = 1'b1;
            state_in = stat.probe_done ? S_IDLE : S_PRD;
         end
         S_BRD: begin
            if (stat.bump_ok) begin
               cmd.bump_read = 1'b1;
               state_in = S_BCHK;
            end else begin
               cmd.bump_skip = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_BCHK: begin
            cmd.bump_write = 1'b1;
            state_in = S_IDLE;
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.cnt_last) state_in = S_SDRAIN;
         end
         S_SDRAIN: begin
            cmd.sweep_end = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### rtl/gcht_datapath.sv
module gcht_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  gcht_pkg::cmd_type        cmd,
   output gcht_pkg::stat_type       stat,
   input  logic [1:0]               req_op,
   input  logic signed [15:0]       req_cell_x,
   input  logic signed [15:0]       req_cell_y,
   input  logic                     req_dynamic_hint,
   input  logic [12:0]              req_target_slot,
   output logic                     rsp_valid,
   output logic [12:0]              rsp_slot_index,
   output logic                     rsp_created,
   output logic                     rsp_table_full,
   output logic                     rsp_force_process,
   output logic [7:0]               rsp_object_count,
   output logic [8:0]               rsp_request_count,
   output logic [27:0]              rsp_load
);

   localparam int SB = gcht_pkg::SLOT_BITS;
   localparam int HB = gcht_pkg::HASH_BITS;
   localparam int CB = gcht_pkg::COUNT_BITS;

   gcht_pkg::slot_status_type status_mem [gcht_pkg::TABLE_SLOTS];
   logic [31:0]               key_mem    [gcht_pkg::TABLE_SLOTS];

   gcht_pkg::slot_status_type st_rd_ff, st_wd;
   logic [31:0]               key_rd_ff;
   logic                      rd_en, st_we, key_we;
   logic [SB-1:0]             rd_addr, wr_addr;

   gcht_pkg::op_type          op_ff;
   logic [15:0]               x_ff, y_ff;
   logic                      hint_ff;
   logic [12:0]               tgt_ff;
   logic [HB-1:0]             px_ff, py_ff, h_ff;
   logic [SB-1:0]             probe_ff, probe_in, first_ff, next_slot;
   logic [SB-1:0]             cnt_ff;
   logic                      sweep_vld_ff;
   logic [SB-1:0]             sweep_addr_ff;
   logic [gcht_pkg::LOAD_BITS-1:0] acc_ff, acc_in;
   logic [2*CB-1:0]           sq;

   logic                      hit_free, hit_match, hit, full;
   logic [CB-1:0]             obj_new;
   logic [gcht_pkg::REQ_BITS-1:0] req_new;

   logic                      emit;
   logic [12:0]               r_slot;
   logic                      r_created, r_full, r_force;
   logic [7:0]                r_obj;
   logic [8:0]                r_req;
   logic [27:0]               r_load;

   // slot count is a power of two: the remainder is the low hash bits
   assign probe_in = h_ff[SB-1:0];

   always_comb begin
      hit_free  = !st_rd_ff.active;
      hit_match = st_rd_ff.active && (key_rd_ff == {x_ff, y_ff});
      hit       = hit_free || hit_match;
      next_slot = (probe_ff == gcht_pkg::LAST_SLOT) ? '0 : probe_ff + 1'b1;
      full      = !hit && (next_slot == first_ff);
      obj_new   = (st_rd_ff.obj < gcht_pkg::COUNT_MAX) ? st_rd_ff.obj + 1'b1 : st_rd_ff.obj;
      req_new   = (st_rd_ff.req < gcht_pkg::REQUEST_MAX) ? st_rd_ff.req + 1'b1 : st_rd_ff.req;
      sq        = st_rd_ff.obj * st_rd_ff.obj;
      acc_in    = acc_ff;
      if (sweep_vld_ff && op_ff == gcht_pkg::OP_LOAD && st_rd_ff.valid)
         acc_in = acc_ff + gcht_pkg::LOAD_BITS'(sq >> 1);
   end

   always_comb begin
      stat.cnt_last   = (cnt_ff == gcht_pkg::LAST_SLOT);
      stat.mod_done   = 1'b1;
      stat.probe_done = hit || full;
      stat.bump_ok    = 32'(tgt_ff) < gcht_pkg::TABLE_SLOTS;
   end

   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = probe_ff;
      st_we     = 1'b0;
      key_we    = 1'b0;
      wr_addr   = probe_ff;
      st_wd     = '0;
      emit      = 1'b0;
      r_slot    = '0;
      r_created = 1'b0;
      r_full    = 1'b0;
      r_force   = 1'b0;
      r_obj     = '0;
      r_req     = '0;
      r_load    = '0;

      if (cmd.clear_step) begin
         st_we   = 1'b1;
         wr_addr = cnt_ff;
      end
      if (cmd.probe_read) rd_en = 1'b1;
      if (cmd.bump_read) begin
         rd_en   = 1'b1;
         rd_addr = SB'(tgt_ff);
      end
      if (cmd.sweep_step) begin
         rd_en   = 1'b1;
         rd_addr = cnt_ff;
      end

      if (cmd.probe_check) begin
         if (hit) begin
            st_we  = 1'b1;
            key_we = 1'b1;
            st_wd  = '{active: 1'b1, valid: 1'b1, force_mark: hint_ff,
                       req: st_rd_ff.req, obj: obj_new};
            emit      = 1'b1;
            r_slot    = 13'(probe_ff);
            r_created = hit_free;
            r_force   = hint_ff;
            r_obj     = 8'(obj_new);
         end else if (full) begin
            emit   = 1'b1;
            r_full = 1'b1;
         end
      end

      if (cmd.bump_write) begin
         st_we     = 1'b1;
         wr_addr   = SB'(tgt_ff);
         st_wd     = st_rd_ff;
         st_wd.req = req_new;
         emit      = 1'b1;
         r_req     = req_new;
      end
      if (cmd.bump_skip) emit = 1'b1;

      if (sweep_vld_ff && op_ff == gcht_pkg::OP_FRAME) begin
         st_we   = 1'b1;
         wr_addr = sweep_addr_ff;
         // keep requested cells alive for one more frame
         if (st_rd_ff.valid && st_rd_ff.req != '0) begin
            st_wd.active = 1'b1;
            st_wd.req    = st_rd_ff.req - 1'b1;
         end
      end
      if (cmd.sweep_end) begin
         emit = 1'b1;
         if (op_ff == gcht_pkg::OP_LOAD) r_load = acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         st_rd_ff  <= status_mem[rd_addr];
         key_rd_ff <= key_mem[rd_addr];
      end
      if (st_we)  status_mem[wr_addr] <= st_wd;
      if (key_we) key_mem[wr_addr]    <= {x_ff, y_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= gcht_pkg::op_type'(req_op);
         x_ff    <= req_cell_x;
         y_ff    <= req_cell_y;
         hint_ff <= req_dynamic_hint;
         tgt_ff  <= req_target_slot;
         acc_ff  <= '0;
      end else begin
         acc_ff  <= acc_in;
      end
      if (cmd.hash_mul) begin
         px_ff <= HB'({{16{x_ff[15]}}, x_ff} * gcht_pkg::HASH_MUL_X);
         py_ff <= HB'({{16{y_ff[15]}}, y_ff} * gcht_pkg::HASH_MUL_Y);
      end
      if (cmd.hash_sum) h_ff <= px_ff + py_ff;
      if (cmd.mod_step) begin
         probe_ff   <= probe_in;
         first_ff   <= probe_in;
      end
      if (cmd.probe_check) probe_ff <= next_slot;
      sweep_addr_ff <= cnt_ff;
      rsp_slot_index    <= r_slot;
      rsp_created       <= r_created;
      rsp_table_full    <= r_full;
      rsp_force_process <= r_force;
      rsp_object_count  <= r_obj;
      rsp_request_count <= r_req;
      rsp_load          <= r_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         sweep_vld_ff <= 1'b0;
         rsp_valid    <= 1'b0;
      end else begin
         if (cmd.capture) cnt_ff <= '0;
         else if (cmd.clear_step || cmd.sweep_step) cnt_ff <= cnt_ff + 1'b1;
         sweep_vld_ff <= cmd.sweep_step;
         rsp_valid    <= emit;
      end
   end

endmodule

### rtl/grid_cell_hash_table.sv
// Grid cell hash table: cells keyed by signed (x,y) in 8192 slots, open
// addressing with linear probing. A request is taken when start is high and
// busy is low; its single response shows on the rsp_ ports for one cycle under
// rsp_valid and must be taken then, since the receiver cannot stall it. After
// reset the block sweeps all slots to clear them, with busy high. An add keeps
// busy high through the hashing steps (multiply, sum, slot select from the
// low hash bits), then a read and a check of each probed slot in the status
// memory. A bump reads the target slot and writes it back, skipped when the
// target is out of range. Frame reset and load sweep the memory one slot a
// cycle, then drain. The response shows in the first cycle busy is low.
module grid_cell_hash_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_cell_x,
   input  logic signed [15:0] req_cell_y,
   input  logic               req_dynamic_hint,
   input  logic [12:0]        req_target_slot,
   output logic               rsp_valid,
   output logic [12:0]        rsp_slot_index,
   output logic               rsp_created,
   output logic               rsp_table_full,
   output logic               rsp_force_process,
   output logic [7:0]         rsp_object_count,
   output logic [8:0]         rsp_request_count,
   output logic [27:0]        rsp_load
);

   gcht_pkg::cmd_type  cmd;
   gcht_pkg::stat_type stat;

   gcht_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   gcht_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_op),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_dynamic_hint  (req_dynamic_hint),
      .req_target_slot   (req_target_slot),
      .rsp_valid         (rsp_valid),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_created       (rsp_created),
      .rsp_table_full    (rsp_table_full),
      .rsp_force_process (rsp_force_process),
      .rsp_object_count  (rsp_object_count),
      .rsp_request_count (rsp_request_count),
      .rsp_load          (rsp_load)
   );

endmodule

### rtl/gcht_checker.sv
module gcht_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [12:0] rsp_slot_index,
   input logic        rsp_created,
   input logic        rsp_table_full,
   input logic [7:0]  rsp_object_count,
   input logic [8:0]  rsp_request_count
);

   // every accepted request raises busy in the cycle after it is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after request");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back response strobes");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_slot_index == 13'd0 && !rsp_created
         && rsp_object_count == 8'd0) else $error("full response carries data");

   a_created_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_created |-> !rsp_table_full && rsp_object_count == 8'd1)
      else $error("new cell without a single object");

   a_req_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_request_count <= 9'd500) else $error("request count over limit");

endmodule

bind grid_cell_hash_table gcht_checker u_gcht_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_slot_index    (rsp_slot_index),
   .rsp_created       (rsp_created),
   .rsp_table_full    (rsp_table_full),
   .rsp_object_count  (rsp_object_count),
   .rsp_request_count (rsp_request_count)
);

### bench/grid_cell_hash_table_test.sv
`timescale 1ns / 100ps

module grid_cell_hash_table_test;
   import gcht_pkg::*;

   typedef struct packed {
      logic [12:0] slot_index;
      logic        created;
      logic        table_full;
      logic        force_process;
      logic [7:0]  object_count;
      logic [8:0]  request_count;
      logic [27:0] load;
   } cell_result_t;

   int error_count = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   class cell_table_board;
      logic [15:0] key_x [TABLE_SLOTS];
      logic [15:0] key_y [TABLE_SLOTS];
      bit          active [TABLE_SLOTS];
      bit          valid [TABLE_SLOTS];
      bit          force_mark [TABLE_SLOTS];
      int unsigned req_cnt [TABLE_SLOTS];
      int unsigned obj_cnt [TABLE_SLOTS];
      cell_result_t pending [$];
      int matched;

      function automatic int unsigned hash_slot(logic signed [15:0] x, logic signed [15:0] y);
         logic [31:0] h;
         logic [31:0] sx;
         logic [31:0] sy;
         sx = 32'(x);
         sy = 32'(y);
         h = sx * HASH_MUL_X + sy * HASH_MUL_Y;
         return h % TABLE_SLOTS;
      endfunction

      function automatic void note_request(op_type op, logic signed [15:0] x,
                                           logic signed [15:0] y, logic hint,
                                           logic [12:0] target);
         cell_result_t r;
         int unsigned s;
         int unsigned first;
         bit made;
         longint unsigned sum;
         r = '0;
         case (op)
            OP_ADD: begin
               first = hash_slot(x, y);
               s = first;
               made = 0;
               forever begin
                  if (!active[s]) begin
                     key_x[s] = x;
                     key_y[s] = y;
                     active[s] = 1;
                     made = 1;
                     break;
                  end
                  if (key_x[s] == x && key_y[s] == y) break;
                  s = (s + 1) % TABLE_SLOTS;
                  if (s == first) begin
                     r.table_full = 1;
                     break;
                  end
               end
               if (!r.table_full) begin
                  valid[s] = 1;
                  if (obj_cnt[s] < COUNT_MAX) obj_cnt[s]++;
                  force_mark[s] = hint;
                  r.slot_index = 13'(s);
                  r.created = made;
                  r.force_process = hint;
                  r.object_count = 8'(obj_cnt[s]);
               end
            end
            OP_BUMP: begin
               if (target < TABLE_SLOTS) begin
                  if (req_cnt[target] < REQUEST_MAX) req_cnt[target]++;
                  r.request_count = 9'(req_cnt[target]);
               end
            end
            OP_FRAME: begin
               for (int i = 0; i < TABLE_SLOTS; i++) begin
                  if (req_cnt[i] > 0 && valid[i]) begin
                     active[i] = 1;
                     req_cnt[i]--;
                  end else begin
                     req_cnt[i] = 0;
                     active[i] = 0;
                  end
                  force_mark[i] = 0;
                  valid[i] = 0;
                  obj_cnt[i] = 0;
               end
            end
            default: begin
               sum = 0;
               for (int i = 0; i < TABLE_SLOTS; i++)
                  if (valid[i]) sum += (obj_cnt[i] * obj_cnt[i]) / 2;
               r.load = sum[27:0];
            end
         endcase
         pending.push_back(r);
      endfunction

      task automatic check_result(cell_result_t got);
         cell_result_t want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
            return;
         end
         want = pending.pop_front();
         matched++;
         if (got.slot_index !== want.slot_index)
            report_mismatch("slot_index", got.slot_index, want.slot_index);
         if (got.created !== want.created)
            report_mismatch("created", got.created, want.created);
         if (got.table_full !== want.table_full)
            report_mismatch("table_full", got.table_full, want.table_full);
         if (got.force_process !== want.force_process)
            report_mismatch("force_process", got.force_process, want.force_process);
         if (got.object_count !== want.object_count)
            report_mismatch("object_count", got.object_count, want.object_count);
         if (got.request_count !== want.request_count)
            report_mismatch("request_count", got.request_count, want.request_count);
         if (got.load !== want.load)
            report_mismatch("load", got.load, want.load);
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_op;
   logic signed [15:0] req_cell_x;
   logic signed [15:0] req_cell_y;
   logic               req_dynamic_hint;
   logic [12:0]        req_target_slot;
   logic               rsp_valid;
   logic [12:0]        rsp_slot_index;
   logic               rsp_created;
   logic               rsp_table_full;
   logic               rsp_force_process;
   logic [7:0]         rsp_object_count;
   logic [8:0]         rsp_request_count;
   logic [27:0]        rsp_load;

   cell_table_board board = new();
   int op_seen [4];
   logic signed [15:0] hot_x [8];
   logic signed [15:0] hot_y [8];

   grid_cell_hash_table dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #500ms;
      $display("timeout");
      $display("grid_cell_hash_table_test: errors");
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_valid)
         board.check_result({rsp_slot_index, rsp_created, rsp_table_full, rsp_force_process,
                             rsp_object_count, rsp_request_count, rsp_load});

   // present one request and hold it until the block takes it; start stays high
   task automatic send_request(op_type op, logic signed [15:0] x, logic signed [15:0] y,
                               logic hint, logic [12:0] target);
      start <= 1;
      req_op <= op;
      req_cell_x <= x;
      req_cell_y <= y;
      req_dynamic_hint <= hint;
      req_target_slot <= target;
      do @(posedge clock); while (busy);
      board.note_request(op, x, y, hint, target);
      op_seen[op]++;
   endtask

   task automatic drain();
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic random_request();
      int pick;
      int k;
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 7);
      if (pick < 60) begin
         // mostly revisit a few hot cells so counts and probes pile up
         if ($urandom_range(0, 2) != 0)
            send_request(OP_ADD, hot_x[k] + 16'($urandom_range(0, 1)), hot_y[k],
                         1'($urandom_range(0, 1)), '0);
         else
            send_request(OP_ADD, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                         13'($urandom));
      end else if (pick < 88) begin
         send_request(OP_BUMP, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(0, 63)));
      end else if (pick < 94) begin
         send_request(OP_FRAME, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                      13'($urandom));
      end else begin
         send_request(OP_LOAD, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                      13'($urandom));
      end
   endtask

   initial begin
      int sent;
      int burst;
      int gap;
      reset = 1;
      start = 0;
      req_op = OP_ADD;
      req_cell_x = 0;
      req_cell_y = 0;
      req_dynamic_hint = 0;
      req_target_slot = 0;
      for (int i = 0; i < 8; i++) begin
         hot_x[i] = 16'($urandom);
         hot_y[i] = 16'($urandom);
      end
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every op, saturations, frame reset keep and drop
      send_request(OP_LOAD, 0, 0, 0, 0);
      send_request(OP_ADD, 16'sh7fff, 16'sh7fff, 1, 0);
      send_request(OP_ADD, -16'sh8000, -16'sh8000, 0, 13'h1fff);
      send_request(OP_ADD, 0, 0, 1, 0);
      send_request(OP_ADD, -1, 1, 0, 0);
      send_request(OP_ADD, 16'sh7fff, 16'sh7fff, 0, 0);
      for (int i = 0; i < 3; i++) send_request(OP_BUMP, 0, 0, 0, 13'h1fff);
      send_request(OP_BUMP, 0, 0, 0, 0);
      send_request(OP_LOAD, 0, 0, 0, 0);
      drain();
      // hold count past 255 on one cell
      for (int i = 0; i < 258; i++) send_request(OP_ADD, 5, -5, i[0], 0);
      for (int i = 0; i < 503; i++) send_request(OP_BUMP, 0, 0, 0, 13'd7);
      send_request(OP_LOAD, 0, 0, 0, 0);
      send_request(OP_FRAME, 0, 0, 0, 0);
      send_request(OP_ADD, 5, -5, 1, 0);
      send_request(OP_LOAD, 0, 0, 0, 0);
      send_request(OP_FRAME, 0, 0, 0, 0);
      send_request(OP_ADD, 16'sh7fff, 16'sh7fff, 0, 0);
      drain();

      sent = 0;
      while (sent < 800) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst; i++) begin
            random_request();
            sent++;
         end
         if (sent > 400 && sent <= 400 + burst) drain();
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
         if (gap != 0) begin
            start <= 0;
            repeat (gap) @(posedge clock);
         end
      end

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d adds, %0d bumps, %0d frame resets, %0d load sums",
               op_seen[OP_ADD], op_seen[OP_BUMP], op_seen[OP_FRAME], op_seen[OP_LOAD]);
      $display("%0d responses compared", board.matched);
      if (error_count == 0 && board.pending.size() == 0)
         $display("grid_cell_hash_table_test: clean");
      else
         $display("grid_cell_hash_table_test: errors");
      $finish;
   end
endmodule

### filelist.f
rtl/gcht_pkg.sv
rtl/gcht_ctrl.sv
rtl/gcht_datapath.sv
rtl/grid_cell_hash_table.sv
rtl/gcht_checker.sv
bench/grid_cell_hash_table_test.sv
